// File: design/tbpd_pkg.sv
// Shared types and constants for the text/binary packet deframer.
// Used by the front classifier, the command queue and the result expander.
package tbpd_pkg;

  localparam logic [7:0] MARKER_RESET = 8'h24;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_LF        = 8'h0A;

  localparam logic KIND_TEXT   = 1'b0;
  localparam logic KIND_BINARY = 1'b1;

  // One command covers everything that a single input byte releases: up to three
  // held terminator bytes, followed by at most one main result.
  typedef struct packed {
    logic       kind;
    logic [1:0] pre_count;
    logic       main_valid;
    logic       main_has_byte;
    logic [7:0] main_byte;
    logic       main_end;
  } cmd_t;

  typedef struct packed {
    logic       packet_kind;
    logic       has_byte;
    logic [7:0] byte_out;
    logic       packet_end;
    logic       run_end;
  } result_t;

endpackage

// File: design/tbpd_front.sv
// Front classifier of the deframer: tracks the packet mode, the length header
// and the terminator match, and turns each input byte into one command.
// Depends on tbpd_pkg.
module tbpd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    byte_in,
  input  logic          cfg_write,
  input  logic [7:0]    cfg_data,
  output logic          cmd_valid,
  output tbpd_pkg::cmd_t cmd
);
  import tbpd_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_TEXT = 2'd1;
  localparam logic [1:0] MODE_HEAD = 2'd2;
  localparam logic [1:0] MODE_DATA = 2'd3;

  logic [7:0]  binary_marker;
  logic [1:0]  mode;
  logic [1:0]  mode_next;
  logic [1:0]  terminator_matched;
  logic [1:0]  terminator_matched_next;
  logic [1:0]  header_count;
  logic [1:0]  header_count_next;
  logic [31:0] bytes_remaining;
  logic [31:0] bytes_remaining_next;
  logic [31:0] length_assembled;
  logic [31:0] length_decremented;
  logic [1:0]  text_matched;
  logic        text_go;
  logic [7:0]  want;

  assign length_assembled   = bytes_remaining | ({24'd0, byte_in} << {header_count, 3'b000});
  assign length_decremented = bytes_remaining - 32'd1;

  always_comb begin
    mode_next               = mode;
    terminator_matched_next = terminator_matched;
    header_count_next       = header_count;
    bytes_remaining_next    = bytes_remaining;
    cmd                     = '0;
    text_matched            = terminator_matched;
    text_go                 = 1'b0;
    want                    = CH_CR;
    if (accept) begin
      unique case (mode)
        MODE_IDLE: begin
          if (byte_in == binary_marker) begin
            mode_next            = MODE_HEAD;
            header_count_next    = 2'd0;
            bytes_remaining_next = 32'd0;
          end else begin
            mode_next    = MODE_TEXT;
            text_matched = 2'd0;
            text_go      = 1'b1;
          end
        end
        MODE_TEXT: begin
          text_go = 1'b1;
        end
        MODE_HEAD: begin
          bytes_remaining_next = length_assembled;
          header_count_next    = header_count + 2'd1;
          if (header_count == 2'd3) begin
            header_count_next = 2'd0;
            if (length_assembled == 32'd0) begin
              cmd.kind       = KIND_BINARY;
              cmd.main_valid = 1'b1;
              cmd.main_end   = 1'b1;
              mode_next      = MODE_IDLE;
            end else begin
              mode_next = MODE_DATA;
            end
          end
        end
        MODE_DATA: begin
          bytes_remaining_next = length_decremented;
          cmd.kind             = KIND_BINARY;
          cmd.main_valid       = 1'b1;
          cmd.main_has_byte    = 1'b1;
          cmd.main_byte        = byte_in;
          cmd.main_end         = (length_decremented == 32'd0);
          if (length_decremented == 32'd0) begin
            mode_next = MODE_IDLE;
          end
        end
        default: begin
          mode_next = MODE_IDLE;
        end
      endcase
    end
    if (text_go) begin
      want = text_matched[0] ? CH_LF : CH_CR;
      cmd.kind = KIND_TEXT;
      if (byte_in == want) begin
        if (text_matched == 2'd3) begin
          cmd.main_valid          = 1'b1;
          cmd.main_end            = 1'b1;
          terminator_matched_next = 2'd0;
          mode_next               = MODE_IDLE;
        end else begin
          terminator_matched_next = text_matched + 2'd1;
        end
      end else begin
        cmd.pre_count = text_matched;
        if (byte_in == CH_CR) begin
          terminator_matched_next = 2'd1;
        end else begin
          cmd.main_valid          = 1'b1;
          cmd.main_has_byte       = 1'b1;
          cmd.main_byte           = byte_in;
          terminator_matched_next = 2'd0;
        end
      end
    end
    cmd_valid = (cmd.pre_count != 2'd0) || cmd.main_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      binary_marker      <= MARKER_RESET;
      mode               <= MODE_IDLE;
      terminator_matched <= 2'd0;
      header_count       <= 2'd0;
      bytes_remaining    <= 32'd0;
    end else begin
      if (cfg_write) begin
        binary_marker <= cfg_data;
      end
      mode               <= mode_next;
      terminator_matched <= terminator_matched_next;
      header_count       <= header_count_next;
      bytes_remaining    <= bytes_remaining_next;
    end
  end

endmodule

// File: design/tbpd_cmd_fifo.sv
// Short command queue between the front classifier and the result expander.
// Register array with wrap-around pointers and an occupancy count.
// Depends on tbpd_pkg.
module tbpd_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  tbpd_pkg::cmd_t wr_data,
  input  logic           rd_en,
  output tbpd_pkg::cmd_t rd_data,
  output logic           full,
  output logic           not_empty
);
  import tbpd_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/tbpd_back.sv
// Result expander of the deframer: steps through the queued command one result
// per cycle while the output is empty or popped, and loads the output register. Depends on tbpd_pkg.
module tbpd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_ready,
  input  tbpd_pkg::cmd_t    cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output tbpd_pkg::result_t result
);
  import tbpd_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic [2:0] total;
  logic       last;
  logic       load;
  result_t    cur;

  assign total = {1'b0, cmd.pre_count} + {2'b00, cmd.main_valid};
  assign last  = ({1'b0, idx} == total - 3'd1);
  assign load  = cmd_ready && (!out_valid || pop);
  assign cmd_pop = load && last;
  assign empty   = !out_valid;

  always_comb begin
    if (idx < cmd.pre_count) begin
      cur.packet_kind = KIND_TEXT;
      cur.has_byte    = 1'b1;
      cur.byte_out    = idx[0] ? CH_LF : CH_CR;
      cur.packet_end  = 1'b0;
    end else begin
      cur.packet_kind = cmd.kind;
      cur.has_byte    = cmd.main_has_byte;
      cur.byte_out    = cmd.main_has_byte ? cmd.main_byte : 8'd0;
      cur.packet_end  = cmd.main_end;
    end
    cur.run_end = last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: design/text_binary_packet_deframer_unit.sv
// Text/binary packet deframer, top level. A byte's command is queued, then the
// expander loads its results into the output register. Input rate: one byte per
// cycle while the command queue has room; output rate: one result per cycle from
// the expander while results are popped, so a byte that releases k results gives
// them in turn. Synchronous active-high reset empties the queue and output, returns
// to idle and restores the binary marker to 0x24. Depends on tbpd_pkg and submodules.
module text_binary_packet_deframer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  output logic       empty,
  input  logic       pop,
  output logic       packet_kind,
  output logic       has_byte,
  output logic [7:0] byte_out,
  output logic       packet_end,
  output logic       run_end
);
  import tbpd_pkg::*;

  logic    accept;
  logic    cmd_valid;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    head_valid;
  logic    head_pop;
  result_t result;

  assign accept = push && !full;

  tbpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .byte_in   (byte_in),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (front_cmd)
  );

  tbpd_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (cmd_valid),
    .wr_data   (front_cmd),
    .rd_en     (head_pop),
    .rd_data   (head_cmd),
    .full      (full),
    .not_empty (head_valid)
  );

  tbpd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_ready (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

  assign packet_kind = result.packet_kind;
  assign has_byte    = result.has_byte;
  assign byte_out    = result.byte_out;
  assign packet_end  = result.packet_end;
  assign run_end     = result.run_end;

endmodule

// File: design/tbpd_checker.sv
// Port-level checks for the deframer top level, attached by a bind statement.
// Depends only on the top level's ports.
module tbpd_port_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic       has_byte,
  input logic [7:0] byte_out,
  input logic       packet_end,
  input logic       run_end
);

  a_empty_after_reset: assert property (@(posedge clk) rst |=> empty)
    else $error("Result queue is not empty after reset.");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(byte_out) && $stable(packet_end)))
    else $error("A waiting result changed before it was taken.");

  a_byteless_is_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (byte_out == 8'd0))
    else $error("A result without a byte carries a nonzero byte.");

  a_byteless_ends: assert property (@(posedge clk) disable iff (rst)
    (!empty && !has_byte) |-> (packet_end && run_end))
    else $error("A result without a byte does not end its packet.");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && packet_end) |-> run_end)
    else $error("A packet end is not the last result of its byte.");

endmodule

bind text_binary_packet_deframer_unit tbpd_port_checker u_tbpd_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .has_byte    (has_byte),
  .byte_out    (byte_out),
  .packet_end  (packet_end),
  .run_end     (run_end)
);
